/* design/utg_pkg.sv */
// shared constants, status codes and font range table for the utf-8 glyph index decoder
package utg_pkg;

    // bytes per glyph in the font image
    localparam int unsigned GLYPH_BYTES = 32;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CODE_W   = 21;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned GLYPH_W  = 15;
    localparam int unsigned OFFSET_W = 20;

    localparam int unsigned NUM_RANGES = 11;

    localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] MASK_CONT   = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_LEAD2  = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'h07;

    typedef enum logic [STATUS_W-1:0] {
        ST_ASCII       = 3'd0,
        ST_IN_FONT     = 3'd1,
        ST_NOT_IN_FONT = 3'd2,
        ST_BAD_LEAD    = 3'd3,
        ST_CONTROL     = 3'd4
    } status_t;

    // first and last code point of each font range, and its first glyph index
    localparam logic [15:0] RANGE_FIRST [NUM_RANGES] = '{
        16'h4E00, 16'h9FA6, 16'h3400, 16'hF900, 16'h3000, 16'hFF00,
        16'hFE10, 16'hFE30, 16'h3200, 16'h31C0, 16'h2F00
    };
    localparam logic [15:0] RANGE_LAST [NUM_RANGES] = '{
        16'h9FA5, 16'h9FD5, 16'h4DB5, 16'hFAD9, 16'h303F, 16'hFFEE,
        16'hFE19, 16'hFE4F, 16'h33FF, 16'h31E3, 16'h2FD5
    };
    localparam logic [GLYPH_W-1:0] RANGE_BASE [NUM_RANGES] = '{
        15'd0,     15'd20902, 15'd20950, 15'd27532, 15'd28006, 15'd28070,
        15'd28309, 15'd28319, 15'd28351, 15'd28863, 15'd28899
    };

endpackage

/* design/utf8_to_glyph_index_unit.sv */
// utf-8 byte stream decoder giving code point, byte count and font glyph index
// the byte completing a result is held in the input register, then decoded into the
//   result register; throughput: one byte per cycle while the output is not stalled,
//   set by the single decode pass over the input register
// lead bytes of longer sequences and inner continuation bytes give no result
// reset (aresetn low, synchronous) empties both registers and returns the decoder to idle
module utf8_to_glyph_index_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    // decoded characters out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [20:0] m_code_point,
    output logic [2:0]  m_byte_count,
    output logic [14:0] m_glyph_index,
    output logic [19:0] m_glyph_offset
);

    // input register
    logic                         in_valid_reg;
    logic [utg_pkg::BYTE_W-1:0]   in_byte_reg;

    // decoder state
    logic [1:0]                   bytes_left_reg, bytes_left_next;
    logic [2:0]                   seq_length_reg, seq_length_next;
    logic [utg_pkg::CODE_W-1:0]   code_accum_reg, code_accum_next;

    // result register
    logic                         out_valid_reg;
    utg_pkg::status_t             status_reg, status_next;
    logic [utg_pkg::CODE_W-1:0]   code_point_reg, code_point_next;
    logic [utg_pkg::COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [utg_pkg::GLYPH_W-1:0]  glyph_index_reg, glyph_index_next;
    logic [utg_pkg::OFFSET_W-1:0] glyph_offset_reg, glyph_offset_next;

    logic                         produce;
    logic                         advance;

    // range lookup
    logic                         found;
    logic [utg_pkg::GLYPH_W-1:0]  font_glyph;
    logic [15:0]                  range_diff;
    logic [31:0]                  offset_full;

    // the held byte moves on once the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // decode of the held byte against the current state
    always_comb begin
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        code_accum_next = code_accum_reg;
        produce         = 1'b0;
        if (bytes_left_reg == 2'd0) begin
            if (in_byte_reg[7] == 1'b0) begin
                // plain ascii completes at once
                seq_length_next = 3'd1;
                code_accum_next = {13'd0, in_byte_reg};
                produce         = 1'b1;
            end else if (in_byte_reg[7:5] == 3'b110) begin
                seq_length_next = 3'd2;
                bytes_left_next = 2'd1;
                code_accum_next = {13'd0, in_byte_reg & utg_pkg::MASK_LEAD2};
            end else if (in_byte_reg[7:4] == 4'b1110) begin
                seq_length_next = 3'd3;
                bytes_left_next = 2'd2;
                code_accum_next = {13'd0, in_byte_reg & utg_pkg::MASK_LEAD3};
            end else if (in_byte_reg[7:3] == 5'b11110) begin
                seq_length_next = 3'd4;
                bytes_left_next = 2'd3;
                code_accum_next = {13'd0, in_byte_reg & utg_pkg::MASK_LEAD4};
            end else begin
                // stray continuation or over-long lead: error, stay idle
                produce = 1'b1;
            end
        end else begin
            // any byte inside a sequence counts as a continuation byte
            code_accum_next = {code_accum_reg[14:0], in_byte_reg[5:0]};
            bytes_left_next = bytes_left_reg - 2'd1;
            produce         = (bytes_left_reg == 2'd1);
        end
    end

    // parallel range compares, first hit wins (ranges do not overlap)
    always_comb begin
        found      = 1'b0;
        font_glyph = '0;
        range_diff = '0;
        for (int i = 0; i < utg_pkg::NUM_RANGES; i++) begin
            if (!found
                && code_accum_next >= {5'd0, utg_pkg::RANGE_FIRST[i]}
                && code_accum_next <= {5'd0, utg_pkg::RANGE_LAST[i]}) begin
                found      = 1'b1;
                range_diff = code_accum_next[15:0] - utg_pkg::RANGE_FIRST[i];
                font_glyph = range_diff[utg_pkg::GLYPH_W-1:0] + utg_pkg::RANGE_BASE[i];
            end
        end
        offset_full = {17'd0, font_glyph} * 32'(utg_pkg::GLYPH_BYTES);
    end

    // result fields
    always_comb begin
        status_next       = utg_pkg::ST_BAD_LEAD;
        code_point_next   = '0;
        byte_count_next   = '0;
        glyph_index_next  = '0;
        glyph_offset_next = '0;
        if (bytes_left_reg == 2'd0) begin
            if (in_byte_reg[7] == 1'b0) begin
                code_point_next = {13'd0, in_byte_reg};
                byte_count_next = 3'd1;
                if (in_byte_reg >= utg_pkg::ASCII_SPACE) begin
                    status_next      = utg_pkg::ST_ASCII;
                    glyph_index_next = {7'd0, in_byte_reg - utg_pkg::ASCII_SPACE};
                end else begin
                    status_next = utg_pkg::ST_CONTROL;
                end
            end
        end else begin
            code_point_next = code_accum_next;
            byte_count_next = seq_length_reg;
            if (found) begin
                status_next       = utg_pkg::ST_IN_FONT;
                glyph_index_next  = font_glyph;
                glyph_offset_next = offset_full[utg_pkg::OFFSET_W-1:0];
            end else begin
                status_next = utg_pkg::ST_NOT_IN_FONT;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            bytes_left_reg <= '0;
            seq_length_reg <= '0;
            code_accum_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                bytes_left_reg <= bytes_left_next;
                seq_length_reg <= seq_length_next;
                code_accum_reg <= code_accum_next;
            end
            if (advance && produce) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_in;
        end
        if (advance && produce) begin
            status_reg       <= status_next;
            code_point_reg   <= code_point_next;
            byte_count_reg   <= byte_count_next;
            glyph_index_reg  <= glyph_index_next;
            glyph_offset_reg <= glyph_offset_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = status_reg;
    assign m_code_point   = code_point_reg;
    assign m_byte_count   = byte_count_reg;
    assign m_glyph_index  = glyph_index_reg;
    assign m_glyph_offset = glyph_offset_reg;

`ifndef SYNTH
    // a font hit only comes from a multibyte sequence
    a_font_multibyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == utg_pkg::ST_IN_FONT |-> m_byte_count >= 3'd2)
        else $error("font hit with fewer than two bytes");

    // bad lead results carry no code point and no length
    a_bad_lead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == utg_pkg::ST_BAD_LEAD |->
        m_code_point == '0 && m_byte_count == '0 && m_glyph_index == '0)
        else $error("bad lead result not cleared");

    // only font hits address the font
    a_offset_font_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != utg_pkg::ST_IN_FONT |-> m_glyph_offset == '0)
        else $error("glyph offset outside a font hit");

    // inside a sequence the remaining count stays below the sequence length
    a_seq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg != 2'd0 |-> seq_length_reg > {1'b0, bytes_left_reg})
        else $error("remaining byte count exceeds sequence length");
`endif

endmodule
